### sv/rgb2hsl_pkg.sv
// Shared types, widths and the long-division step for the RGB to HSL pixel pipeline.
// No dependencies; imported by the channel interfaces and by rgb_to_hsl_pixel.
package rgb2hsl_pkg;

    // Field widths of the pixel and result channels
    localparam int CH_W    = 8;
    localparam int HUE_W   = 15;
    localparam int FRAC_W  = 16;

    // Dividend is {remainder, low word}; the low word is consumed one bit per stage
    localparam int DIV_STEPS = FRAC_W;
    localparam int SUM_W     = CH_W + 1;
    localparam int NUM_W     = 12;
    localparam int HALF_SUM  = 255;
    localparam int FULL_SUM  = 510;

    // Channel that holds the largest value (red wins ties, then green)
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // One restoring-division lane: partial remainder, shifting dividend/quotient, divisor
    typedef struct packed {
        logic [CH_W-1:0]   rem;
        logic [FRAC_W-1:0] lo;
        logic [CH_W-1:0]   dvs;
    } t_lane;

    // Contents of one divider stage
    typedef struct packed {
        logic              vld;
        logic [FRAC_W-1:0] light;
        t_lane             sat;
        t_lane             hue;
    } t_div_stage;

    // Bring down one dividend bit, compare and subtract, shift the quotient bit in
    function automatic t_lane div_step(t_lane a);
        logic [CH_W:0] t;
        t_lane         y;
        y = a;
        t = {a.rem, a.lo[FRAC_W-1]};
        if (t >= {1'b0, a.dvs}) begin
            y.rem = CH_W'(t - {1'b0, a.dvs});
            y.lo  = {a.lo[FRAC_W-2:0], 1'b1};
        end else begin
            y.rem = t[CH_W-1:0];
            y.lo  = {a.lo[FRAC_W-2:0], 1'b0};
        end
        return y;
    endfunction

endpackage

### sv/rgb2hsl_pix_if.sv
// Pixel request channel: valid/ready handshake carrying red, green and blue bytes.
// Depends on rgb2hsl_pkg for the channel width.
interface rgb2hsl_pix_if import rgb2hsl_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### sv/rgb2hsl_hsl_if.sv
// Result request channel: valid/ready handshake carrying hue, saturation and lightness.
// Depends on rgb2hsl_pkg for the field widths.
interface rgb2hsl_hsl_if import rgb2hsl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [HUE_W-1:0]  hue;
    logic [FRAC_W-1:0] saturation;
    logic [FRAC_W-1:0] lightness;

    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    output ready);
endinterface

### sv/rgb_to_hsl_pixel.sv
// RGB to HSL pixel converter: top level, a fully pipelined datapath with an output skid stage.
// Depends on rgb2hsl_pkg and the rgb2hsl_pix_if / rgb2hsl_hsl_if channel interfaces.
//
// Converts one 8-bit RGB pixel per clock to hue (degrees x 64, 0..23039), saturation and
// lightness (fractions x 65535), all truncated exactly. A new pixel is accepted every cycle
// while the result side keeps taking. The path from pixel request to result is
// three front stages (max/min, sector numerator and lightness, dividend set-up) and
// sixteen restoring-division stages, one quotient bit each, with saturation and hue
// divided side by side, then the output register. A two-entry output buffer keeps the
// input ready a register, so a stalled result never loses or repeats a pixel.
module rgb_to_hsl_pixel import rgb2hsl_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rgb2hsl_pix_if.sink     i_pix,
    rgb2hsl_hsl_if.source   o_hsl
);

    // Pipeline advance: hold every pipeline stage while the skid entry is occupied
    logic pipe_adv;

    // Stage A: max, min, sector and the channels
    logic            r_a_vld;
    logic [CH_W-1:0] r_a_red, r_a_grn, r_a_blu, r_a_mx, r_a_mn;
    t_sector         r_a_sec;
    logic [CH_W-1:0] n_a_mx, n_a_mn;
    t_sector         n_a_sec;

    // Stage B: difference, denominator, wrapped hue numerator, lightness
    logic              r_b_vld;
    logic [CH_W-1:0]   r_b_d, r_b_den;
    logic [NUM_W-2:0]  r_b_num;
    logic              r_b_grey;
    logic [FRAC_W-1:0] r_b_light;
    logic [CH_W-1:0]   n_b_d, n_b_den;
    logic [SUM_W-1:0]  n_b_s;
    logic [NUM_W-1:0]  n_b_raw, n_b_wrap;
    logic [FRAC_W-1:0] n_b_light;

    // Divider stages: index 0 is the set-up, each later index one quotient bit
    t_div_stage r_div [0:DIV_STEPS];
    t_div_stage n_div0;
    logic [CH_W+FRAC_W-1:0] n_sat_num, n_hue_num;

    // Output register and skid entry
    logic              r_out_vld, r_skid_vld;
    logic [HUE_W-1:0]  r_out_hue, r_skid_hue;
    logic [FRAC_W-1:0] r_out_sat, r_skid_sat, r_out_light, r_skid_light;

    assign pipe_adv    = !r_skid_vld;
    assign i_pix.ready = !r_skid_vld;

    // Stage A: largest and smallest channel, red tested first then green
    always_comb begin
        n_a_mx  = i_pix.red;
        n_a_sec = SEC_RED;
        if (i_pix.green > n_a_mx) begin
            n_a_mx  = i_pix.green;
            n_a_sec = SEC_GREEN;
        end
        if (i_pix.blue > n_a_mx) begin
            n_a_mx  = i_pix.blue;
            n_a_sec = SEC_BLUE;
        end
        n_a_mn = i_pix.red;
        if (i_pix.green < n_a_mn) n_a_mn = i_pix.green;
        if (i_pix.blue < n_a_mn)  n_a_mn = i_pix.blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (pipe_adv) begin
            r_a_vld <= i_pix.valid;
        end
        if (pipe_adv) begin
            r_a_red <= i_pix.red;
            r_a_grn <= i_pix.green;
            r_a_blu <= i_pix.blue;
            r_a_mx  <= n_a_mx;
            r_a_mn  <= n_a_mn;
            r_a_sec <= n_a_sec;
        end
    end

    // Stage B: sector numerator (modulo 2^NUM_W, top bit is the sign), wrap, lightness
    always_comb begin
        n_b_d   = r_a_mx - r_a_mn;
        n_b_s   = {1'b0, r_a_mx} + {1'b0, r_a_mn};
        n_b_den = (n_b_s < SUM_W'(HALF_SUM)) ? n_b_s[CH_W-1:0]
                                              : CH_W'(SUM_W'(FULL_SUM) - n_b_s);
        case (r_a_sec)
            SEC_RED: begin
                n_b_raw = NUM_W'(r_a_grn) - NUM_W'(r_a_blu);
            end
            SEC_GREEN: begin
                n_b_raw = (NUM_W'(n_b_d) << 1) + NUM_W'(r_a_blu) - NUM_W'(r_a_red);
            end
            SEC_BLUE: begin
                n_b_raw = (NUM_W'(n_b_d) << 2) + NUM_W'(r_a_red) - NUM_W'(r_a_grn);
            end
            default: begin
                n_b_raw = '0;
            end
        endcase
        n_b_wrap = n_b_raw;
        if (n_b_raw[NUM_W-1]) begin
            n_b_wrap = n_b_raw + (NUM_W'(n_b_d) << 2) + (NUM_W'(n_b_d) << 1);
        end
        // s * 65535 / 510 is exactly s * 128.5
        n_b_light = (FRAC_W'(n_b_s) << 7) + FRAC_W'(n_b_s >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (pipe_adv) begin
            r_b_vld <= r_a_vld;
        end
        if (pipe_adv) begin
            r_b_d     <= n_b_d;
            r_b_den   <= n_b_den;
            r_b_num   <= n_b_wrap[NUM_W-2:0];
            r_b_grey  <= (r_a_mx == r_a_mn);
            r_b_light <= n_b_light;
        end
    end

    // Set-up: dividends d*65535 and num*3840 by shift and subtract; grey divides zero by one
    always_comb begin
        n_sat_num = {r_b_d, FRAC_W'(0)} - (CH_W+FRAC_W)'(r_b_d);
        n_hue_num = ((CH_W+FRAC_W)'(r_b_num) << 12) - ((CH_W+FRAC_W)'(r_b_num) << 8);
        n_div0.vld     = r_b_vld;
        n_div0.light   = r_b_light;
        n_div0.sat.rem = n_sat_num[CH_W+FRAC_W-1:FRAC_W];
        n_div0.sat.lo  = n_sat_num[FRAC_W-1:0];
        n_div0.sat.dvs = r_b_grey ? CH_W'(1) : r_b_den;
        n_div0.hue.rem = n_hue_num[CH_W+FRAC_W-1:FRAC_W];
        n_div0.hue.lo  = n_hue_num[FRAC_W-1:0];
        n_div0.hue.dvs = r_b_grey ? CH_W'(1) : r_b_d;
    end

    // Divider pipeline: one quotient bit per stage in both lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_div[k].vld <= 1'b0;
            end
        end else if (pipe_adv) begin
            r_div[0] <= n_div0;
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_div[k+1].vld   <= r_div[k].vld;
                r_div[k+1].light <= r_div[k].light;
                r_div[k+1].sat   <= div_step(r_div[k].sat);
                r_div[k+1].hue   <= div_step(r_div[k].hue);
            end
        end
    end

    // Output register with skid entry: drain skid first, park a result when stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (o_hsl.ready || !r_out_vld) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= r_div[DIV_STEPS].vld;
            end
        end else if (r_div[DIV_STEPS].vld && pipe_adv) begin
            r_skid_vld <= 1'b1;
        end

        if (o_hsl.ready || !r_out_vld) begin
            if (r_skid_vld) begin
                r_out_hue   <= r_skid_hue;
                r_out_sat   <= r_skid_sat;
                r_out_light <= r_skid_light;
            end else begin
                r_out_hue   <= r_div[DIV_STEPS].hue.lo[HUE_W-1:0];
                r_out_sat   <= r_div[DIV_STEPS].sat.lo;
                r_out_light <= r_div[DIV_STEPS].light;
            end
        end else if (pipe_adv) begin
            r_skid_hue   <= r_div[DIV_STEPS].hue.lo[HUE_W-1:0];
            r_skid_sat   <= r_div[DIV_STEPS].sat.lo;
            r_skid_light <= r_div[DIV_STEPS].light;
        end
    end

    assign o_hsl.valid      = r_out_vld;
    assign o_hsl.hue        = r_out_hue;
    assign o_hsl.saturation = r_out_sat;
    assign o_hsl.lightness  = r_out_light;

endmodule
